FILE: rtl/agd_pkg.sv
// ----------------------------------------------------------------------------
// Accelerometer gesture detector package
// Widths, reset values, codes and types that the gesture detector uses.
// ----------------------------------------------------------------------------
package agd_pkg;

    // Sample and timestamp widths.
    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;

    // Configuration field widths.
    localparam int MS_W        = 16;
    localparam int JERK_THR_W  = 19;
    localparam int DEV_W       = 12;
    localparam int AZ_W        = 16;
    localparam int CFG_DATA_W  = 19;
    localparam int CFG_IDX_W   = 3;

    // Jerk accumulation.
    localparam int JERK_W = 20;
    localparam int DJ_W   = SAMPLE_BITS + 2;
    localparam int JSUM_W = ((JERK_W > DJ_W) ? JERK_W : DJ_W) + 1;
    localparam logic [JERK_W-1:0] JERK_MAX = '1;

    // Squared magnitude and the squared bounds it is compared with.
    localparam int ONE_G   = 4096;
    localparam int MAG_W   = 2 * SAMPLE_BITS + 2;
    localparam int BOUND_W = 13;
    localparam int BSQ_W   = 2 * BOUND_W;
    localparam int SCMP_W  = (MAG_W > BSQ_W) ? MAG_W : BSQ_W;

    // Width for the signed z threshold compares.
    localparam int ZCMP_W = (SAMPLE_BITS > AZ_W) ? SAMPLE_BITS : AZ_W;

    // Stream payload widths.
    localparam int IN_W        = 3 * SAMPLE_BITS + TIME_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int EV_W        = 3;
    localparam int OUT_TDATA_W = 8;

    // Register reset values.
    localparam logic [MS_W-1:0]       SHAKE_WINDOW_RST = MS_W'(300);
    localparam logic [JERK_THR_W-1:0] SHAKE_JERK_RST   = JERK_THR_W'(16384);
    localparam int                    STILL_DEV_RST    = 205;
    localparam logic [MS_W-1:0]       STILL_MS_RST     = MS_W'(2000);
    localparam int                    PICKUP_DEV_RST   = 614;
    localparam logic signed [AZ_W-1:0] FLIP_DOWN_RST   = -AZ_W'(3686);
    localparam logic signed [AZ_W-1:0] FLIP_UP_RST     = AZ_W'(3686);
    localparam logic [MS_W-1:0]       FLIP_HOLD_RST    = MS_W'(1000);

    localparam logic [BSQ_W-1:0] STILL_LO_SQ_RST =
        BSQ_W'((ONE_G - STILL_DEV_RST) * (ONE_G - STILL_DEV_RST));
    localparam logic [BSQ_W-1:0] STILL_HI_SQ_RST =
        BSQ_W'((ONE_G + STILL_DEV_RST) * (ONE_G + STILL_DEV_RST));
    localparam logic [BSQ_W-1:0] PICK_LO_SQ_RST =
        BSQ_W'((ONE_G - PICKUP_DEV_RST) * (ONE_G - PICKUP_DEV_RST));
    localparam logic [BSQ_W-1:0] PICK_HI_SQ_RST =
        BSQ_W'((ONE_G + PICKUP_DEV_RST) * (ONE_G + PICKUP_DEV_RST));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAKE_WINDOW = 3'd0,
        CFG_SHAKE_JERK   = 3'd1,
        CFG_STILL_DEV    = 3'd2,
        CFG_STILL_MS     = 3'd3,
        CFG_PICKUP_DEV   = 3'd4,
        CFG_FLIP_DOWN    = 3'd5,
        CFG_FLIP_UP      = 3'd6,
        CFG_FLIP_HOLD    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FACE_NEUTRAL = 2'd0,
        FACE_DOWN    = 2'd1,
        FACE_UP      = 2'd2
    } face_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE      = 3'd0,
        EV_SHAKE     = 3'd1,
        EV_PICKUP    = 3'd2,
        EV_FLIP_DOWN = 3'd3,
        EV_FLIP_UP   = 3'd4
    } event_t;

endpackage

FILE: rtl/accel_gesture_detector_top.sv
// ----------------------------------------------------------------------------
// Accelerometer gesture detector
// Reports shake, pickup and flip events from timestamped 3-axis samples.
// ----------------------------------------------------------------------------
// One event code comes out for every sample request taken in. The block takes
// a new sample in every cycle while the result register is free or being read.
// A sample enters the input register at the edge that accepts it, and its
// event enters the result register once that register is free or being read;
// the result then stays offered until m_axis_tready takes it. While a result
// waits, the input register still takes one more sample; after that
// s_axis_tready stays low until the result leaves. The three squarers sit in
// front of the input register; the jerk, stillness and face updates are
// combinational between the input and result registers, which is what allows
// a sample per clock. Register writes take effect at the edge of the write;
// the two deviation registers are stored as squared magnitude bounds.
module accel_gesture_detector_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration
    input  logic                              cfg_we,
    input  logic [agd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [agd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Samples
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // accel_x, accel_y, accel_z, time_ms from the lowest bit up
    input  logic [agd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Events
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // event_code in the lowest bits
    output logic [agd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import agd_pkg::*;

    // Configuration registers.
    logic [MS_W-1:0]              shake_window_reg;
    logic [JERK_THR_W-1:0]        shake_jerk_reg;
    logic [MS_W-1:0]              still_ms_reg;
    logic signed [AZ_W-1:0]       flip_down_reg;
    logic signed [AZ_W-1:0]       flip_up_reg;
    logic [MS_W-1:0]              flip_hold_reg;
    logic [BSQ_W-1:0]             still_lo_sq_reg;
    logic [BSQ_W-1:0]             still_hi_sq_reg;
    logic [BSQ_W-1:0]             pick_lo_sq_reg;
    logic [BSQ_W-1:0]             pick_hi_sq_reg;

    logic [BOUND_W-1:0]           cfg_lo;
    logic [BOUND_W-1:0]           cfg_hi;
    logic [BSQ_W-1:0]             cfg_lo_sq;
    logic [BSQ_W-1:0]             cfg_hi_sq;

    // Input stage.
    logic                         in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg, y_reg, z_reg;
    logic [TIME_BITS-1:0]         time_reg;
    logic [MAG_W-1:0]             mag_sq_reg;

    logic signed [SAMPLE_BITS-1:0] s_x, s_y, s_z;
    logic signed [2*SAMPLE_BITS-1:0] sq_x, sq_y, sq_z;
    logic [MAG_W-1:0]             mag_in;

    // Output stage.
    logic                         out_valid_reg;
    event_t                       event_reg, event_next;

    // Detector state.
    logic signed [SAMPLE_BITS-1:0] last_x_reg, last_y_reg, last_z_reg;
    logic                         have_last_reg;
    logic [JERK_W-1:0]            jerk_total_reg, jerk_total_next;
    logic [TIME_BITS-1:0]         jerk_time_reg, jerk_time_next;
    logic                         still_flag_reg, still_flag_next;
    logic [TIME_BITS-1:0]         still_start_reg, still_start_next;
    face_t                        face_dir_reg, face_dir_next;
    logic [TIME_BITS-1:0]         face_start_reg, face_start_next;
    logic                         face_done_reg, face_done_next;

    // Step logic.
    logic                         advance;
    logic                         step_en;
    logic [SAMPLE_BITS-1:0]       ad_x, ad_y, ad_z;
    logic [DJ_W-1:0]              dj;
    logic [TIME_BITS-1:0]         jerk_gap, still_gap, face_gap;
    logic [JERK_W-1:0]            jerk_base;
    logic [JSUM_W-1:0]            jerk_sum;
    logic [JERK_W-1:0]            jerk_sat;
    logic                         shake_hit;
    logic [SCMP_W-1:0]            mag;
    logic                         is_still;
    logic                         big_dev;
    logic                         pickup_hit;
    logic signed [ZCMP_W-1:0]     z_ext, down_ext, up_ext;
    face_t                        face_new;
    logic                         flip_hit;

    function automatic logic [SAMPLE_BITS-1:0] abs_diff(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b
    );
        logic signed [SAMPLE_BITS:0] d;
        d = (SAMPLE_BITS+1)'(a) - (SAMPLE_BITS+1)'(b);
        abs_diff = d[SAMPLE_BITS] ? SAMPLE_BITS'(-d) : SAMPLE_BITS'(d);
    endfunction

    // ------------------------------------------------------------------
    // Configuration: the deviation registers are kept as squared bounds.
    // ------------------------------------------------------------------
    assign cfg_lo    = BOUND_W'(ONE_G) - BOUND_W'(cfg_data[DEV_W-1:0]);
    assign cfg_hi    = BOUND_W'(ONE_G) + BOUND_W'(cfg_data[DEV_W-1:0]);
    assign cfg_lo_sq = BSQ_W'(cfg_lo) * BSQ_W'(cfg_lo);
    assign cfg_hi_sq = BSQ_W'(cfg_hi) * BSQ_W'(cfg_hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shake_window_reg <= SHAKE_WINDOW_RST;
            shake_jerk_reg   <= SHAKE_JERK_RST;
            still_ms_reg     <= STILL_MS_RST;
            flip_down_reg    <= FLIP_DOWN_RST;
            flip_up_reg      <= FLIP_UP_RST;
            flip_hold_reg    <= FLIP_HOLD_RST;
            still_lo_sq_reg  <= STILL_LO_SQ_RST;
            still_hi_sq_reg  <= STILL_HI_SQ_RST;
            pick_lo_sq_reg   <= PICK_LO_SQ_RST;
            pick_hi_sq_reg   <= PICK_HI_SQ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SHAKE_WINDOW: shake_window_reg <= cfg_data[MS_W-1:0];
                CFG_SHAKE_JERK:   shake_jerk_reg   <= cfg_data[JERK_THR_W-1:0];
                CFG_STILL_DEV:
                begin
                    still_lo_sq_reg <= cfg_lo_sq;
                    still_hi_sq_reg <= cfg_hi_sq;
                end
                CFG_STILL_MS:     still_ms_reg     <= cfg_data[MS_W-1:0];
                CFG_PICKUP_DEV:
                begin
                    pick_lo_sq_reg <= cfg_lo_sq;
                    pick_hi_sq_reg <= cfg_hi_sq;
                end
                CFG_FLIP_DOWN:    flip_down_reg    <= signed'(cfg_data[AZ_W-1:0]);
                CFG_FLIP_UP:      flip_up_reg      <= signed'(cfg_data[AZ_W-1:0]);
                CFG_FLIP_HOLD:    flip_hold_reg    <= cfg_data[MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control.
    // ------------------------------------------------------------------
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(event_reg);

    // Squared magnitude is formed on the way into the input register.
    assign s_x  = signed'(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign s_y  = signed'(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign s_z  = signed'(s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
    assign sq_x = s_x * s_x;
    assign sq_y = s_y * s_y;
    assign sq_z = s_z * s_z;
    assign mag_in = MAG_W'($unsigned(sq_x)) + MAG_W'($unsigned(sq_y))
                  + MAG_W'($unsigned(sq_z));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            x_reg      <= s_x;
            y_reg      <= s_y;
            z_reg      <= s_z;
            time_reg   <= s_axis_tdata[IN_W-1:3*SAMPLE_BITS];
            mag_sq_reg <= mag_in;
        end
        if (step_en)
        begin
            event_reg <= event_next;
        end
    end

    // ------------------------------------------------------------------
    // Detector update for the sample in the input register.
    // ------------------------------------------------------------------
    assign ad_x = abs_diff(x_reg, last_x_reg);
    assign ad_y = abs_diff(y_reg, last_y_reg);
    assign ad_z = abs_diff(z_reg, last_z_reg);
    assign dj   = DJ_W'(ad_x) + DJ_W'(ad_y) + DJ_W'(ad_z);

    // Time differences wrap with the timestamp.
    assign jerk_gap  = time_reg - jerk_time_reg;
    assign still_gap = time_reg - still_start_reg;
    assign face_gap  = time_reg - face_start_reg;

    assign jerk_base = (jerk_gap > TIME_BITS'(shake_window_reg)) ? '0 : jerk_total_reg;
    assign jerk_sum  = JSUM_W'(jerk_base) + JSUM_W'(dj);
    assign jerk_sat  = (jerk_sum > JSUM_W'(JERK_MAX)) ? JERK_MAX : JERK_W'(jerk_sum);
    assign shake_hit = have_last_reg && (jerk_sat >= JERK_W'(shake_jerk_reg));

    assign mag      = SCMP_W'(mag_sq_reg);
    assign is_still = (mag > SCMP_W'(still_lo_sq_reg)) && (mag < SCMP_W'(still_hi_sq_reg));
    assign big_dev  = (mag > SCMP_W'(pick_hi_sq_reg)) || (mag < SCMP_W'(pick_lo_sq_reg));
    assign pickup_hit = !is_still && still_flag_reg && big_dev
                     && (still_gap >= TIME_BITS'(still_ms_reg));

    assign z_ext    = ZCMP_W'(z_reg);
    assign down_ext = ZCMP_W'(flip_down_reg);
    assign up_ext   = ZCMP_W'(flip_up_reg);

    always_comb
    begin
        // The face-down test wins when the thresholds overlap.
        if (z_ext <= down_ext)
        begin
            face_new = FACE_DOWN;
        end
        else if (z_ext >= up_ext)
        begin
            face_new = FACE_UP;
        end
        else
        begin
            face_new = face_dir_reg;
        end
    end

    assign flip_hit = (face_new == face_dir_reg) && (face_dir_reg != FACE_NEUTRAL)
                   && !face_done_reg && (face_gap >= TIME_BITS'(flip_hold_reg));

    always_comb
    begin
        jerk_total_next  = jerk_total_reg;
        jerk_time_next   = jerk_time_reg;
        still_flag_next  = still_flag_reg;
        still_start_next = still_start_reg;
        face_dir_next    = face_dir_reg;
        face_start_next  = face_start_reg;
        face_done_next   = face_done_reg;

        if (have_last_reg)
        begin
            jerk_time_next  = time_reg;
            jerk_total_next = shake_hit ? '0 : jerk_sat;
        end

        if (is_still)
        begin
            if (!still_flag_reg)
            begin
                still_flag_next  = 1'b1;
                still_start_next = time_reg;
            end
        end
        else
        begin
            still_flag_next = 1'b0;
        end

        if (face_new != face_dir_reg)
        begin
            face_dir_next   = face_new;
            face_start_next = time_reg;
            face_done_next  = 1'b0;
        end
        else if (flip_hit)
        begin
            face_done_next = 1'b1;
        end

        if (shake_hit)
        begin
            event_next = EV_SHAKE;
        end
        else if (pickup_hit)
        begin
            event_next = EV_PICKUP;
        end
        else if (flip_hit)
        begin
            event_next = (face_dir_reg == FACE_DOWN) ? EV_FLIP_DOWN : EV_FLIP_UP;
        end
        else
        begin
            event_next = EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            last_z_reg      <= '0;
            have_last_reg   <= 1'b0;
            jerk_total_reg  <= '0;
            jerk_time_reg   <= '0;
            still_flag_reg  <= 1'b0;
            still_start_reg <= '0;
            face_dir_reg    <= FACE_NEUTRAL;
            face_start_reg  <= '0;
            face_done_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            last_x_reg      <= x_reg;
            last_y_reg      <= y_reg;
            last_z_reg      <= z_reg;
            have_last_reg   <= 1'b1;
            jerk_total_reg  <= jerk_total_next;
            jerk_time_reg   <= jerk_time_next;
            still_flag_reg  <= still_flag_next;
            still_start_reg <= still_start_next;
            face_dir_reg    <= face_dir_next;
            face_start_reg  <= face_start_next;
            face_done_reg   <= face_done_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A face that has been reported is never the neutral one.
    a_done_face: assert property (@(posedge clk) disable iff (!rst_n)
        face_done_reg |-> (face_dir_reg != FACE_NEUTRAL))
        else $error("reported face is neutral");

    // No jerk accumulates before a previous sample exists.
    a_jerk_first: assert property (@(posedge clk) disable iff (!rst_n)
        !have_last_reg |-> (jerk_total_reg == '0))
        else $error("jerk total set before first sample");

    // The first sample after reset can never report a shake.
    a_no_first_shake: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && !have_last_reg) |=> (event_reg != EV_SHAKE))
        else $error("shake on first sample");

    // A processed sample always lands in the result register.
    a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("result lost");

    // A sample held by a stalled output keeps its slot and its timestamp.
    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(time_reg)))
        else $error("input stage changed under stall");

endmodule
